/* sv/lagms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagms_pkg
// Shared types and constants of the link aggregation member select table.
// ----------------------------------------------------------------------------
package lagms_pkg;

  // Request codes on the input channel
  localparam logic [1:0] REQ_DIST = 2'd0;
  localparam logic [1:0] REQ_ADD  = 2'd1;
  localparam logic [1:0] REQ_DEL  = 2'd2;
  localparam logic [1:0] REQ_CLR  = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_DOWN   = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_ABSENT = 3'd4;

  // Number of physical ports known to the table
  localparam int PORTS = 32;

  // Hash fold and remainder unit: 8 hash bits reduced per cycle
  localparam int HASH_W        = 32;
  localparam int FOLD_SHIFT    = 11;
  localparam int MOD_STEP_BITS = 8;
  localparam int MOD_STEPS     = HASH_W / MOD_STEP_BITS;
  localparam int MOD_STEP_W    = $clog2(MOD_STEPS);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // Classified command kinds
  typedef enum logic [2:0] {
    CMD_FIXED,  // group out of range: result known up front
    CMD_DIST,
    CMD_ADD,
    CMD_DEL,
    CMD_CLR,
    CMD_MISS    // add/delete of an unknown port
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [2:0]         fixed_status;
    logic [3:0]         group;
    logic [4:0]         port;
    logic [HASH_W-1:0]  hash;
  } cmd_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DECODE,
    BK_MOD,
    BK_PICK,
    BK_SCAN,
    BK_SHIFT,
    BK_DONE
  } bk_state_t;

endpackage

/* sv/lagms_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagms_in_if / lagms_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface lagms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  group_select;
  logic [4:0]  member_port;
  logic [31:0] dest_tail;
  logic [31:0] src_tail;

  modport source (
    output valid, req_type, group_select, member_port, dest_tail, src_tail,
    input  ready
  );
  modport sink (
    input  valid, req_type, group_select, member_port, dest_tail, src_tail,
    output ready
  );
endinterface

interface lagms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] out_port;
  logic [2:0] member_total;

  modport source (
    output valid, status, out_port, member_total,
    input  ready
  );
  modport sink (
    input  valid, status, out_port, member_total,
    output ready
  );
endinterface

/* sv/lagms_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagms_front
// Accepts request items, checks ranges, folds the frame hash and pushes a
// classified command into the queue.
// ----------------------------------------------------------------------------
module lagms_front #(
  parameter int GROUPS = 16
) (
  lagms_in_if.sink          in_if,
  input  logic              q_full,
  output logic              q_push,
  output lagms_pkg::cmd_t   q_cmd
);

  logic                        grp_bad;
  logic                        port_bad;
  logic [lagms_pkg::HASH_W-1:0] mix;

  // Handshake: take an item whenever the queue has room
  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  assign grp_bad  = 32'(in_if.group_select) >= 32'(GROUPS);
  assign port_bad = 32'(in_if.member_port) >= 32'(lagms_pkg::PORTS);
  assign mix      = in_if.dest_tail ^ in_if.src_tail;

  // Classification
  always_comb begin
    q_cmd.group        = in_if.group_select;
    q_cmd.port         = in_if.member_port;
    q_cmd.hash         = mix ^ (mix >> lagms_pkg::FOLD_SHIFT);
    q_cmd.fixed_status = lagms_pkg::ST_OK;
    q_cmd.kind         = lagms_pkg::CMD_FIXED;
    unique case (in_if.req_type)
      lagms_pkg::REQ_DIST: begin
        q_cmd.fixed_status = lagms_pkg::ST_EMPTY;
        q_cmd.kind         = lagms_pkg::CMD_DIST;
      end
      lagms_pkg::REQ_ADD: begin
        q_cmd.fixed_status = lagms_pkg::ST_FULL;
        q_cmd.kind = port_bad ? lagms_pkg::CMD_MISS : lagms_pkg::CMD_ADD;
      end
      lagms_pkg::REQ_DEL: begin
        q_cmd.fixed_status = lagms_pkg::ST_ABSENT;
        q_cmd.kind = port_bad ? lagms_pkg::CMD_MISS : lagms_pkg::CMD_DEL;
      end
      lagms_pkg::REQ_CLR: begin
        q_cmd.fixed_status = lagms_pkg::ST_OK;
        q_cmd.kind         = lagms_pkg::CMD_CLR;
      end
      default: begin
        q_cmd.kind = lagms_pkg::CMD_FIXED;
      end
    endcase
    // out-of-range group overrides everything
    if (grp_bad) begin
      q_cmd.kind = lagms_pkg::CMD_FIXED;
    end
  end

endmodule

/* sv/lagms_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagms_fifo
// Short command queue that lets front and back stall independently.
// ----------------------------------------------------------------------------
module lagms_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lagms_pkg::cmd_t  push_cmd,
  input  logic             pop,
  output lagms_pkg::cmd_t  head_cmd,
  output logic             full,
  output logic             empty
);

  localparam int PW = lagms_pkg::QUEUE_PTR_W;

  lagms_pkg::cmd_t q_r [lagms_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     fill_r;
  logic [PW:0]     fill_nxt;

  assign full     = fill_r == (PW+1)'(lagms_pkg::QUEUE_DEPTH);
  assign empty    = fill_r == '0;
  assign head_cmd = q_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (PW+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (PW+1)'(1);
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* sv/lagms_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagms_back
// Executes commands: member table memory, per-group counts, remainder unit,
// delete scan/compaction and the result register.
// ----------------------------------------------------------------------------
module lagms_back #(
  parameter int GROUPS            = 16,
  parameter int MEMBERS_PER_GROUP = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  input  lagms_pkg::cmd_t  head_cmd,
  input  logic             q_empty,
  output logic             q_pop,
  lagms_out_if.source      out_if
);

  localparam int CW      = $clog2(MEMBERS_PER_GROUP + 1);
  localparam int GIW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int ENTRIES = GROUPS * MEMBERS_PER_GROUP;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SB      = lagms_pkg::MOD_STEP_BITS;
  localparam int SW      = lagms_pkg::MOD_STEP_W;

  localparam logic [SW-1:0] STEP_LAST = SW'(lagms_pkg::MOD_STEPS - 1);

  // One remainder step per hash bit, eight bits per call
  function automatic logic [CW-1:0] mod_step8(input logic [CW-1:0] r_in,
                                               input logic [SB-1:0] bits,
                                               input logic [CW-1:0] div);
    logic [CW:0]   t;
    logic [CW-1:0] r;
    r = r_in;
    for (int i = SB - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
      r = t[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic [2:0] to_total(input logic [CW-1:0] c);
    logic [CW+2:0] e;
    e = {3'b000, c};
    return e[2:0];
  endfunction

  lagms_pkg::bk_state_t state_r, state_nxt;
  lagms_pkg::cmd_t      cmd_r;

  logic [31:0]   mask_r;
  logic [CW-1:0] count_r [GROUPS];
  logic [4:0]    mem [ENTRIES];
  logic [4:0]    rd_data_r;

  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [lagms_pkg::HASH_W-1:0] hsh_r, hsh_nxt;
  logic [SW-1:0] step_r, step_nxt;

  logic [2:0] res_status_r, res_status_nxt;
  logic [4:0] res_port_r, res_port_nxt;
  logic [2:0] res_total_r, res_total_nxt;
  logic       res_load;

  logic       out_valid_r;
  logic [2:0] out_status_r;
  logic [4:0] out_port_r;
  logic [2:0] out_total_r;
  logic       res_slot_open;
  logic       take;

  logic [GIW+3:0] g_ext;
  logic [GIW-1:0] gidx;
  logic [CW-1:0]  cnt;
  logic [AW-1:0]  base;
  logic [CW:0]    k1;
  logic [CW:0]    k2;
  logic [CW-1:0]  rem_step;
  logic           hit;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [4:0]    mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic          cnt_we;
  logic [CW-1:0] cnt_wd;

  // Group addressing and current count
  assign g_ext    = {{GIW{1'b0}}, cmd_r.group};
  assign gidx     = g_ext[GIW-1:0];
  assign cnt      = count_r[gidx];
  assign base     = AW'(gidx) * AW'(MEMBERS_PER_GROUP);
  assign k1       = {1'b0, k_r} + (CW+1)'(1);
  assign k2       = {1'b0, k_r} + (CW+1)'(2);
  assign hit      = rd_data_r == cmd_r.port;
  assign rem_step = mod_step8(rem_r, hsh_r[lagms_pkg::HASH_W-1 -: SB], cnt);

  // Result register handshake and queue pop
  assign res_slot_open = !out_valid_r || out_if.ready;
  assign take          = !q_empty &&
                         ((state_r == lagms_pkg::BK_IDLE) ||
                          ((state_r == lagms_pkg::BK_DONE) && res_slot_open));
  assign q_pop         = take;

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.out_port     = out_port_r;
  assign out_if.member_total = out_total_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lagms_pkg::BK_IDLE: begin
        if (take) state_nxt = lagms_pkg::BK_DECODE;
      end
      lagms_pkg::BK_DECODE: begin
        unique case (cmd_r.kind)
          lagms_pkg::CMD_DIST: begin
            if (cnt == '0) state_nxt = lagms_pkg::BK_DONE;
            else if (cnt == CW'(1)) state_nxt = lagms_pkg::BK_PICK;
            else state_nxt = lagms_pkg::BK_MOD;
          end
          lagms_pkg::CMD_DEL: begin
            state_nxt = (cnt == '0) ? lagms_pkg::BK_DONE : lagms_pkg::BK_SCAN;
          end
          default: state_nxt = lagms_pkg::BK_DONE;
        endcase
      end
      lagms_pkg::BK_MOD: begin
        if (step_r == STEP_LAST) begin
          state_nxt = lagms_pkg::BK_PICK;
        end
      end
      lagms_pkg::BK_PICK: state_nxt = lagms_pkg::BK_DONE;
      lagms_pkg::BK_SCAN: begin
        if (k1 < {1'b0, cnt}) begin
          state_nxt = hit ? lagms_pkg::BK_SHIFT : lagms_pkg::BK_SCAN;
        end else begin
          state_nxt = lagms_pkg::BK_DONE;
        end
      end
      lagms_pkg::BK_SHIFT: begin
        if (!(k2 < {1'b0, cnt})) state_nxt = lagms_pkg::BK_DONE;
      end
      lagms_pkg::BK_DONE: begin
        if (res_slot_open) begin
          state_nxt = take ? lagms_pkg::BK_DECODE : lagms_pkg::BK_IDLE;
        end
      end
      default: state_nxt = lagms_pkg::BK_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    mem_we         = 1'b0;
    mem_wa         = base + AW'(k_r);
    mem_wd         = cmd_r.port;
    mem_re         = 1'b0;
    mem_ra         = base;
    cnt_we         = 1'b0;
    cnt_wd         = cnt;
    res_load       = 1'b0;
    res_status_nxt = lagms_pkg::ST_OK;
    res_port_nxt   = '0;
    res_total_nxt  = to_total(cnt);
    k_nxt          = k_r;
    rem_nxt        = rem_r;
    hsh_nxt        = hsh_r;
    step_nxt       = step_r;
    unique case (state_r)
      lagms_pkg::BK_DECODE: begin
        unique case (cmd_r.kind)
          lagms_pkg::CMD_FIXED: begin
            res_load       = 1'b1;
            res_status_nxt = cmd_r.fixed_status;
            res_total_nxt  = '0;
          end
          lagms_pkg::CMD_MISS: begin
            res_load       = 1'b1;
            res_status_nxt = lagms_pkg::ST_ABSENT;
          end
          lagms_pkg::CMD_CLR: begin
            cnt_we        = 1'b1;
            cnt_wd        = '0;
            res_load      = 1'b1;
            res_total_nxt = '0;
          end
          lagms_pkg::CMD_ADD: begin
            res_load = 1'b1;
            if (cnt >= CW'(MEMBERS_PER_GROUP)) begin
              res_status_nxt = lagms_pkg::ST_FULL;
            end else begin
              mem_we        = 1'b1;
              mem_wa        = base + AW'(cnt);
              cnt_we        = 1'b1;
              cnt_wd        = cnt + CW'(1);
              res_total_nxt = to_total(cnt + CW'(1));
            end
          end
          lagms_pkg::CMD_DIST: begin
            if (cnt == '0) begin
              res_load       = 1'b1;
              res_status_nxt = lagms_pkg::ST_EMPTY;
            end else if (cnt == CW'(1)) begin
              mem_re = 1'b1;
            end else begin
              rem_nxt  = '0;
              hsh_nxt  = cmd_r.hash;
              step_nxt = '0;
            end
          end
          lagms_pkg::CMD_DEL: begin
            if (cnt == '0) begin
              res_load       = 1'b1;
              res_status_nxt = lagms_pkg::ST_ABSENT;
            end else begin
              mem_re = 1'b1;
              k_nxt  = '0;
            end
          end
          default: begin
            res_load = 1'b0;
          end
        endcase
      end
      // hash remainder, most significant byte first
      lagms_pkg::BK_MOD: begin
        rem_nxt  = rem_step;
        hsh_nxt  = hsh_r << SB;
        step_nxt = step_r + SW'(1);
        mem_ra   = base + AW'(rem_step);
        if (step_r == STEP_LAST) begin
          mem_re = 1'b1;
        end
      end
      lagms_pkg::BK_PICK: begin
        res_load = 1'b1;
        if (mask_r[rd_data_r]) begin
          res_port_nxt = rd_data_r;
        end else begin
          res_status_nxt = lagms_pkg::ST_DOWN;
        end
      end
      // look for the first matching entry
      lagms_pkg::BK_SCAN: begin
        mem_ra = base + AW'(k1);
        if (k1 < {1'b0, cnt}) begin
          mem_re = 1'b1;
          if (!hit) k_nxt = k1[CW-1:0];
        end else if (hit) begin
          cnt_we        = 1'b1;
          cnt_wd        = cnt - CW'(1);
          res_load      = 1'b1;
          res_total_nxt = to_total(cnt - CW'(1));
        end else begin
          res_load       = 1'b1;
          res_status_nxt = lagms_pkg::ST_ABSENT;
        end
      end
      // move entry k+1 down to k
      lagms_pkg::BK_SHIFT: begin
        mem_we = 1'b1;
        mem_wd = rd_data_r;
        k_nxt  = k1[CW-1:0];
        mem_ra = base + AW'(k2);
        if (k2 < {1'b0, cnt}) begin
          mem_re = 1'b1;
        end else begin
          cnt_we        = 1'b1;
          cnt_wd        = cnt - CW'(1);
          res_load      = 1'b1;
          res_total_nxt = to_total(cnt - CW'(1));
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lagms_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
      for (int g = 0; g < GROUPS; g++) begin
        count_r[g] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
      if (cnt_we) begin
        count_r[gidx] <= cnt_wd;
      end
      if ((state_r == lagms_pkg::BK_DONE) && res_slot_open) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= head_cmd;
    end
    k_r    <= k_nxt;
    rem_r  <= rem_nxt;
    hsh_r  <= hsh_nxt;
    step_r <= step_nxt;
    if (res_load) begin
      res_status_r <= res_status_nxt;
      res_port_r   <= res_port_nxt;
      res_total_r  <= res_total_nxt;
    end
    if ((state_r == lagms_pkg::BK_DONE) && res_slot_open) begin
      out_status_r <= res_status_r;
      out_port_r   <= res_port_r;
      out_total_r  <= res_total_r;
    end
  end

  // Member table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

endmodule

/* sv/lag_member_select_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lag_member_select_table_core
// Link aggregation member lists with hash based egress port selection.
// ----------------------------------------------------------------------------
// From the queue head, add, clear and rejected items pass decode straight to
// the result register; distribute with one member reads its single entry and
// picks it, otherwise the remainder unit first reduces 8 hash bits a cycle;
// delete scans and shifts entries through the member table's single read port.
// The next item is taken once the last is done. Synchronous active-low reset
// clears counts, port mask, queue and result valid flag; table RAM is not reset.
// ----------------------------------------------------------------------------
module lag_member_select_table_core #(
  parameter int GROUPS            = 16,
  parameter int MEMBERS_PER_GROUP = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  lagms_in_if.sink     in_if,
  lagms_out_if.source  out_if,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);

  lagms_pkg::cmd_t push_cmd;
  lagms_pkg::cmd_t head_cmd;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;

  lagms_front #(
    .GROUPS (GROUPS)
  ) u_front (
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  lagms_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  lagms_back #(
    .GROUPS            (GROUPS),
    .MEMBERS_PER_GROUP (MEMBERS_PER_GROUP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head_cmd  (head_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_if    (out_if)
  );

endmodule
